@@ rtl/ntc_pkg.sv @@
// Package with the types, codes and helper functions of the numeric type converter.
`timescale 1ns / 1ps
package ntc_pkg;

    localparam logic [2:0] TY_F32 = 3'd0;
    localparam logic [2:0] TY_F16 = 3'd1;
    localparam logic [2:0] TY_U32 = 3'd2;
    localparam logic [2:0] TY_I32 = 3'd3;
    localparam logic [2:0] TY_U8  = 3'd4;
    localparam logic [2:0] TY_I8  = 3'd5;

    localparam logic [0:0] REG_SOURCE = 1'b0;
    localparam logic [0:0] REG_TARGET = 1'b1;

    typedef struct packed {
        logic [31:0] element_bits;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        clipped;
        logic        last_result;
    } out_item_t;

    // Operation class chosen at decode.
    typedef enum logic [2:0] {
        OP_ZERO,
        OP_PASS,
        OP_TO_FLOAT,
        OP_TO_INT,
        OP_SPECIAL
    } op_t;

    // Decoded operand: value = (-1)^sign * mant * 2^(exp).
    typedef struct packed {
        op_t         op;
        logic [2:0]  dst;
        logic        sign;
        logic        is_inf;
        logic [31:0] mant;
        logic signed [9:0] exp;
        logic [31:0] special;
        logic        last;
    } dec_t;

    // Normalized operand: mant has its top bit at 31 (or is zero).
    typedef struct packed {
        op_t         op;
        logic [2:0]  dst;
        logic        sign;
        logic        is_inf;
        logic        zero;
        logic [31:0] mant;
        logic signed [9:0] big;
        logic [31:0] special;
        logic        last;
    } norm_t;

    function automatic logic [31:0] width_mask(input logic [2:0] ty);
        logic [31:0] m;
        begin
            case (ty)
                TY_F32, TY_U32, TY_I32: m = 32'hFFFF_FFFF;
                TY_F16:                 m = 32'h0000_FFFF;
                TY_U8, TY_I8:           m = 32'h0000_00FF;
                default:                m = 32'h0;
            endcase
            return m;
        end
    endfunction

endpackage

@@ rtl/ntc_decode.sv @@
// Decode stage: unpacks the source element into sign, magnitude and exponent.
`timescale 1ns / 1ps
module ntc_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vin,
    input  ntc_pkg::in_item_t din,
    input  logic [2:0]        src,
    input  logic [2:0]        dst,
    output logic              vout,
    output ntc_pkg::dec_t     dout
);

    ntc_pkg::dec_t d_next;
    ntc_pkg::dec_t d_reg;
    logic          v_reg;

    always_comb
    begin
        logic [31:0] b;
        logic        s16;
        logic        s32;
        logic [4:0]  e16;
        logic [7:0]  e32;
        logic [9:0]  f16;
        logic [22:0] f32;
        logic        neg;
        logic [31:0] ival;
        logic        dst_f;
        b     = din.element_bits;
        s16   = b[15];
        e16   = b[14:10];
        f16   = b[9:0];
        s32   = b[31];
        e32   = b[30:23];
        f32   = b[22:0];
        dst_f = (dst == ntc_pkg::TY_F32) || (dst == ntc_pkg::TY_F16);
        d_next         = '0;
        d_next.dst     = dst;
        d_next.last    = din.last_element;
        d_next.op      = ntc_pkg::OP_ZERO;
        neg  = 1'b0;
        ival = b;
        if (src > ntc_pkg::TY_I8 || dst > ntc_pkg::TY_I8) begin
            d_next.op = ntc_pkg::OP_ZERO;
        end else if (src == dst) begin
            d_next.op      = ntc_pkg::OP_SPECIAL;
            d_next.special = b & ntc_pkg::width_mask(src);
        end else if (src == ntc_pkg::TY_F16) begin
            d_next.sign = s16;
            d_next.mant = {21'd0, e16 != 5'd0, f16};
            d_next.exp  = (e16 != 5'd0) ? 10'(signed'({5'd0, e16})) - 10'sd25 : -10'sd24;
            if (e16 == 5'h1F) begin
                if (f16 != 10'd0) begin
                    if (dst == ntc_pkg::TY_F32) begin
                        d_next.op = ntc_pkg::OP_SPECIAL;
                        d_next.special = {s16, 31'h7FC0_0000} | {9'd0, f16, 13'd0};
                    end else begin
                        d_next.op = ntc_pkg::OP_SPECIAL;
                        d_next.special = 32'd0;
                        d_next.is_inf  = 1'b1; // marks NaN clip
                    end
                end else if (dst == ntc_pkg::TY_F32) begin
                    d_next.op = ntc_pkg::OP_SPECIAL;
                    d_next.special = {s16, 31'h7F80_0000};
                end else begin
                    d_next.op = ntc_pkg::OP_TO_INT;
                    d_next.is_inf = 1'b1;
                end
            end else begin
                d_next.op = dst_f ? ntc_pkg::OP_TO_FLOAT : ntc_pkg::OP_TO_INT;
            end
        end else if (src == ntc_pkg::TY_F32) begin
            d_next.sign = s32;
            d_next.mant = {8'd0, e32 != 8'd0, f32};
            d_next.exp  = (e32 != 8'd0) ? 10'(signed'({2'd0, e32})) - 10'sd150 : -10'sd149;
            if (e32 == 8'hFF) begin
                if (f32 != 23'd0) begin
                    d_next.op = ntc_pkg::OP_SPECIAL;
                    if (dst == ntc_pkg::TY_F16) begin
                        d_next.special = {16'd0, s32, 15'h7E00} | {22'd0, f32[22:13]};
                    end else begin
                        d_next.special = 32'd0;
                        d_next.is_inf  = 1'b1;
                    end
                end else if (dst == ntc_pkg::TY_F16) begin
                    d_next.op = ntc_pkg::OP_SPECIAL;
                    d_next.special = {16'd0, s32, 15'h7C00};
                end else begin
                    d_next.op = ntc_pkg::OP_TO_INT;
                    d_next.is_inf = 1'b1;
                end
            end else begin
                d_next.op = dst_f ? ntc_pkg::OP_TO_FLOAT : ntc_pkg::OP_TO_INT;
            end
        end else begin
            case (src)
                ntc_pkg::TY_I32:
                begin
                    neg  = b[31];
                    ival = b;
                end
                ntc_pkg::TY_U8:
                begin
                    ival = {24'd0, b[7:0]};
                end
                ntc_pkg::TY_I8:
                begin
                    neg  = b[7];
                    ival = {{24{b[7]}}, b[7:0]};
                end
                default:
                begin
                    ival = b;
                end
            endcase
            if (dst_f) begin
                d_next.op   = ntc_pkg::OP_TO_FLOAT;
                d_next.sign = neg;
                d_next.mant = neg ? (32'd0 - ival) : ival;
                d_next.exp  = 10'sd0;
            end else begin
                d_next.op      = ntc_pkg::OP_SPECIAL;
                d_next.special = ival & ntc_pkg::width_mask(dst);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

@@ rtl/ntc_normalize.sv @@
// Normalize stage: shifts the magnitude so its leading one sits at bit 31.
`timescale 1ns / 1ps
module ntc_normalize
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  ntc_pkg::dec_t  din,
    output logic           vout,
    output ntc_pkg::norm_t dout
);

    ntc_pkg::norm_t n_next;
    ntc_pkg::norm_t n_reg;
    logic           v_reg;

    always_comb
    begin
        logic [4:0]  lz;
        logic [31:0] m;
        m  = din.mant;
        lz = 5'd0;
        // Five-level priority shifter.
        if (m[31:16] == 16'd0) begin m = m << 16; lz = lz + 5'd16; end
        if (m[31:24] == 8'd0)  begin m = m << 8;  lz = lz + 5'd8;  end
        if (m[31:28] == 4'd0)  begin m = m << 4;  lz = lz + 5'd4;  end
        if (m[31:30] == 2'd0)  begin m = m << 2;  lz = lz + 5'd2;  end
        if (m[31] == 1'b0)     begin m = m << 1;  lz = lz + 5'd1;  end
        n_next         = '0;
        n_next.op      = din.op;
        n_next.dst     = din.dst;
        n_next.sign    = din.sign;
        n_next.is_inf  = din.is_inf;
        n_next.zero    = (din.mant == 32'd0);
        n_next.mant    = m;
        n_next.big     = din.exp + 10'sd31 - 10'(signed'({5'd0, lz}));
        n_next.special = din.special;
        n_next.last    = din.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            n_reg <= n_next;
        end
    end

    assign vout = v_reg;
    assign dout = n_reg;

endmodule

@@ rtl/ntc_encode.sv @@
// Encode stage: rounds to the float target or truncates and saturates to an integer.
`timescale 1ns / 1ps
module ntc_encode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  ntc_pkg::norm_t     din,
    output logic               vout,
    output ntc_pkg::out_item_t dout
);

    ntc_pkg::out_item_t o_next;
    ntc_pkg::out_item_t o_reg;
    logic               v_reg;

    always_comb
    begin
        logic        is16;
        logic signed [9:0] emin;
        logic signed [9:0] emaxv;
        logic signed [9:0] sh;
        logic [5:0]  shu;
        logic [63:0] wide;
        logic [31:0] r;
        logic        g;
        logic        st;
        logic [25:0] rr;
        logic signed [9:0] bexp;
        logic [31:0] fres;
        logic [31:0] mag;
        logic [31:0] ires;
        logic        clip;
        logic        huge;
        logic [31:0] hi;
        logic [31:0] lo;
        is16  = (din.dst == ntc_pkg::TY_F16);
        emin  = is16 ? -10'sd14 : -10'sd126;
        emaxv = is16 ? 10'sd15 : 10'sd127;
        // Right shift of the 32-bit normalized mantissa that leaves p bits.
        sh = (is16 ? 10'sd21 : 10'sd8) + ((din.big < emin) ? (emin - din.big) : 10'sd0);
        shu = (sh > 10'sd40) ? 6'd40 : sh[5:0];
        wide = {din.mant, 32'd0} >> shu;
        r  = wide[63:32];
        g  = wide[31];
        st = (wide[30:0] != 31'd0);
        rr = {1'b0, r[24:0]} + {25'd0, g & (st | r[0])};
        bexp = (din.big < emin) ? emin : din.big;
        if (is16 ? rr[11] : rr[24]) begin
            rr   = rr >> 1;
            bexp = bexp + 10'sd1;
        end
        if (din.zero) begin
            fres = 32'd0;
        end else if (is16 ? (rr[10] == 1'b0) : (rr[23] == 1'b0)) begin
            fres = {6'd0, rr};
        end else if (bexp > emaxv) begin
            fres = is16 ? 32'h7C00 : 32'h7F80_0000;
        end else if (is16) begin
            fres = {17'd0, 5'(bexp + 10'sd15), rr[9:0]};
        end else begin
            fres = {1'b0, 8'(bexp + 10'sd127), rr[22:0]};
        end
        if (is16) begin
            fres[15] = din.sign;
        end else begin
            fres[31] = din.sign;
        end

        // Integer path: truncation toward zero, with saturation.
        huge = din.is_inf || (!din.zero && din.big >= 10'sd33);
        if (din.zero || din.big < 10'sd0) begin
            mag = 32'd0;
        end else if (din.big > 10'sd31) begin
            mag = 32'hFFFF_FFFF;
        end else begin
            mag = din.mant >> (5'd31 - din.big[4:0]);
        end
        case (din.dst)
            ntc_pkg::TY_U32: begin hi = 32'hFFFF_FFFF; lo = 32'd0; end
            ntc_pkg::TY_I32: begin hi = 32'h7FFF_FFFF; lo = 32'h8000_0000; end
            ntc_pkg::TY_U8:  begin hi = 32'd255;       lo = 32'd0; end
            default:         begin hi = 32'd127;       lo = 32'd128; end
        endcase
        clip = 1'b0;
        if (huge || din.big == 10'sd32) begin
            clip = 1'b1;
            ires = din.sign ? lo : hi;
            if (din.sign && (din.dst == ntc_pkg::TY_U32 || din.dst == ntc_pkg::TY_U8)) begin
                ires = 32'd0;
            end
        end else if (din.sign) begin
            if (mag > lo) begin
                clip = 1'b1;
                ires = 32'd0 - lo;
            end else begin
                ires = 32'd0 - mag;
            end
        end else if (mag > hi) begin
            clip = 1'b1;
            ires = hi;
        end else begin
            ires = mag;
        end
        ires = ires & ntc_pkg::width_mask(din.dst);

        o_next.last_result = din.last;
        case (din.op)
            ntc_pkg::OP_TO_FLOAT:
            begin
                o_next.result_bits = fres;
                o_next.clipped     = 1'b0;
            end
            ntc_pkg::OP_TO_INT:
            begin
                o_next.result_bits = ires;
                o_next.clipped     = clip;
            end
            ntc_pkg::OP_SPECIAL:
            begin
                o_next.result_bits = din.special;
                o_next.clipped     = din.is_inf;
            end
            default:
            begin
                o_next.result_bits = 32'd0;
                o_next.clipped     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            o_reg <= o_next;
        end
    end

    assign vout = v_reg;
    assign dout = o_reg;

endmodule

@@ rtl/numeric_type_converter_core.sv @@
// Top level of the numeric type converter: configuration port and three-stage pipeline.
`timescale 1ns / 1ps
// Path: an accepted element is registered in the decode, normalize and encode stages in turn;
// the encode register drives the output.
// Throughput: one element per cycle unless the output stalls; each stage holds one.
// A stalled output freezes the whole pipeline, so no element is lost or repeated.
// Reset clears the stage valid bits and both type registers to fp32.
module numeric_type_converter_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ntc_pkg::out_item_t  out_data
);

    logic [2:0] source_type_reg;
    logic [2:0] target_type_reg;
    logic       en;
    logic       v1;
    logic       v2;
    ntc_pkg::dec_t  d1;
    ntc_pkg::norm_t d2;

    // The pipeline advances whenever the output slot is empty or being drained.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;

    // Register writes complete in the access phase; paddr[2] selects the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            source_type_reg <= ntc_pkg::TY_F32;
            target_type_reg <= ntc_pkg::TY_F32;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == ntc_pkg::REG_SOURCE) begin
                source_type_reg <= pwdata[2:0];
            end else begin
                target_type_reg <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == ntc_pkg::REG_SOURCE) ? {29'd0, source_type_reg}
                                                      : {29'd0, target_type_reg};

    ntc_decode u_decode
    (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (in_valid),
        .din  (in_data),
        .src  (source_type_reg),
        .dst  (target_type_reg),
        .vout (v1),
        .dout (d1)
    );

    ntc_normalize u_normalize
    (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v1),
        .din  (d1),
        .vout (v2),
        .dout (d2)
    );

    ntc_encode u_encode
    (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v2),
        .din  (d2),
        .vout (out_valid),
        .dout (out_data)
    );

`ifndef SYNTH
    // A held output must keep its payload while stalled through the pipeline.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed during stall");
    // Input ready is high exactly when the output slot is empty or being drained.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output drain");
    // Clipping only happens on an integer target; a clipped result is never the fp32 infinity pattern.
    a_clip_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clipped |-> out_data.result_bits[31:0] != 32'h7F80_0000)
        else $error("clip flag on a float result");
`endif

endmodule

@@ verif/numeric_type_converter_core_test.sv @@
// Self-checking testbench of the numeric type converter core with its own conversion model.
`timescale 1ns / 1ps
module numeric_type_converter_core_test;
    import ntc_pkg::*;

    localparam int ITEMS_PER_SETTING = 28;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    numeric_type_converter_core uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Elements waiting to be offered, and converted results still owed by the block.
    in_item_t pending_elems[$];
    out_item_t expected_conversions[$];

    // Our copy of the two type registers, updated whenever a write lands.
    logic [2:0] src_ty = TY_F32;
    logic [2:0] dst_ty = TY_F32;

    // Idle percentages for the sender and the receiver in the current phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The stimulus flips this to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    bit in_taken = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;

    int phase_idx;
    int k;
    int si;
    int di;
    in_item_t elem;

    // Highest set bit of a nonzero magnitude.
    function automatic int msb_index(input longint unsigned m);
        int n;
        begin
            n = 0;
            while (n < 63 && (m >> (n + 1)) != 0)
                n++;
            return n;
        end
    endfunction

    function automatic logic [31:0] type_mask(input logic [2:0] ty);
        case (ty)
            TY_F32, TY_U32, TY_I32: return 32'hFFFF_FFFF;
            TY_F16:                 return 32'h0000_FFFF;
            TY_U8, TY_I8:           return 32'h0000_00FF;
            default:                return 32'h0;
        endcase
    endfunction

    // Rounds (-1)^s * m * 2^e to binary32 or binary16, ties to even, overflow to infinity.
    function automatic logic [31:0] round_to_float(input bit s, input longint unsigned m,
                                                   input int e, input bit half_prec);
        int p;
        int emax;
        int emin;
        int q;
        int sh;
        int big;
        longint unsigned r;
        longint unsigned rem;
        longint unsigned half;
        longint unsigned hid;
        logic [31:0] expmask;
        logic [31:0] sb;
        begin
            p = half_prec ? 11 : 24;
            emax = half_prec ? 15 : 127;
            emin = 1 - emax;
            expmask = half_prec ? 32'h1F : 32'hFF;
            sb = half_prec ? {16'b0, s, 15'b0} : {s, 31'b0};
            hid = 64'd1 << (p - 1);
            if (m == 0)
                return sb;
            big = msb_index(m) + e;
            q = ((big < emin) ? emin : big) - (p - 1);
            sh = q - e;
            if (sh > 63)
                r = 0;
            else if (sh > 0)
            begin
                rem = m & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                r = m >> sh;
                if (rem > half || (rem == half && r[0]))
                    r++;
            end
            else
                r = m << (-sh);
            if ((r >> p) != 0)
            begin
                r = r >> 1;
                q++;
            end
            if (r < hid)
                return sb | r[31:0];
            if (q + p - 1 > emax)
                return sb | (expmask << (p - 1));
            return sb | (32'(q + p - 1 + emax) << (p - 1)) | 32'(r - hid);
        end
    endfunction

    // Truncates a float toward zero into an integer type, saturating; cls 1 is inf, 2 is NaN.
    function automatic logic [32:0] truncate_to_int(input bit s, input int cls,
                                                    input longint unsigned m, input int e,
                                                    input logic [2:0] dst);
        longint v;
        longint lo;
        longint hi;
        bit huge;
        bit clip;
        longint unsigned mag;
        begin
            huge = 1'b0;
            clip = 1'b0;
            mag = 0;
            case (dst)
                TY_U32:  begin lo = 0; hi = 64'd4294967295; end
                TY_I32:  begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
                TY_U8:   begin lo = 0; hi = 255; end
                default: begin lo = -128; hi = 127; end
            endcase
            if (cls == 2)
                return {32'h0, 1'b1};
            if (cls == 1)
                huge = 1'b1;
            else if (m != 0)
            begin
                if (e >= 0)
                begin
                    if (msb_index(m) + e >= 33)
                        huge = 1'b1;
                    else
                        mag = m << e;
                end
                else
                    mag = (-e >= 64) ? 64'd0 : (m >> (-e));
            end
            if (huge)
            begin
                clip = 1'b1;
                v = s ? lo : hi;
            end
            else
            begin
                v = s ? -longint'(mag) : longint'(mag);
                if (v < lo)
                begin
                    v = lo;
                    clip = 1'b1;
                end
                else if (v > hi)
                begin
                    v = hi;
                    clip = 1'b1;
                end
            end
            return {v[31:0] & type_mask(dst), clip};
        end
    endfunction

    // Expected output item for one element under the current type registers.
    function automatic out_item_t convert_element(input in_item_t it);
        out_item_t o;
        logic [31:0] bits;
        logic [32:0] ti;
        bit s;
        bit neg;
        int ex;
        int e;
        int cls;
        logic [22:0] fr;
        longint unsigned m;
        longint unsigned v;
        begin
            bits = it.element_bits;
            o.result_bits = '0;
            o.clipped = 1'b0;
            o.last_result = it.last_element;
            if (src_ty > TY_I8 || dst_ty > TY_I8)
                o.result_bits = '0;
            else if (src_ty == dst_ty)
                o.result_bits = bits & type_mask(src_ty);
            else if (src_ty == TY_F32 || src_ty == TY_F16)
            begin
                if (src_ty == TY_F16)
                begin
                    s = bits[15];
                    ex = int'(bits[14:10]);
                    fr = {13'b0, bits[9:0]};
                    cls = (ex == 31) ? ((fr != 0) ? 2 : 1) : 0;
                    m = (ex != 0) ? (64'(fr) | 64'h400) : 64'(fr);
                    e = (ex != 0) ? ex - 25 : -24;
                end
                else
                begin
                    s = bits[31];
                    ex = int'(bits[30:23]);
                    fr = bits[22:0];
                    cls = (ex == 255) ? ((fr != 0) ? 2 : 1) : 0;
                    m = (ex != 0) ? (64'(fr) | 64'h80_0000) : 64'(fr);
                    e = (ex != 0) ? ex - 150 : -149;
                end
                if (dst_ty == TY_F16)
                begin
                    // A NaN stays quiet and keeps its top payload bits.
                    if (cls == 2)
                        o.result_bits = {16'b0, s, 15'h0} | 32'h7E00 | 32'(fr >> 13);
                    else if (cls == 1)
                        o.result_bits = {16'b0, s, 15'h0} | 32'h7C00;
                    else
                        o.result_bits = round_to_float(s, m, e, 1'b1);
                end
                else if (dst_ty == TY_F32)
                begin
                    if (cls == 2)
                        o.result_bits = {s, 31'h0} | 32'h7FC0_0000 | (32'(fr) << 13);
                    else if (cls == 1)
                        o.result_bits = {s, 31'h0} | 32'h7F80_0000;
                    else
                        o.result_bits = round_to_float(s, m, e, 1'b0);
                end
                else
                begin
                    ti = truncate_to_int(s, cls, m, e, dst_ty);
                    o.result_bits = ti[32:1];
                    o.clipped = ti[0];
                end
            end
            else
            begin
                case (src_ty)
                    TY_U32:
                    begin
                        v = 64'(bits);
                        neg = 1'b0;
                    end
                    TY_I32:
                    begin
                        neg = bits[31];
                        v = {{32{bits[31]}}, bits};
                    end
                    TY_U8:
                    begin
                        v = 64'(bits[7:0]);
                        neg = 1'b0;
                    end
                    default:
                    begin
                        neg = bits[7];
                        v = {{56{bits[7]}}, bits[7:0]};
                    end
                endcase
                if (dst_ty == TY_F32 || dst_ty == TY_F16)
                    o.result_bits = round_to_float(neg, neg ? (64'd0 - v) : v, 0,
                                                   dst_ty == TY_F16);
                else
                    o.result_bits = v[31:0] & type_mask(dst_ty);
            end
            return o;
        end
    endfunction

    // Builds raw source bits, biased toward the corners of the given source type.
    function automatic logic [31:0] pick_bits(input logic [2:0] ty, input int n);
        logic [31:0] r;
        logic [7:0] ex8;
        logic [4:0] ex5;
        logic [22:0] fr;
        int pick;
        begin
            r = $urandom;
            pick = $urandom_range(0, 9);
            case (ty)
                TY_F32:
                begin
                    // Zeros, infinities, NaN and the largest finite value lead each phase.
                    case (n)
                        0: return 32'h0000_0000;
                        1: return 32'h8000_0000;
                        2: return 32'h7F80_0000;
                        3: return 32'hFF80_0000;
                        4: return 32'h7FC0_0001 | (r & 32'h803F_FFFF);
                        5: return 32'h7F7F_FFFF;
                        default: ;
                    endcase
                    case (pick)
                        0: ex8 = 8'd0;
                        1: ex8 = 8'd255;
                        2, 3: ex8 = 8'(127 + $urandom_range(0, 34));
                        4, 5: ex8 = 8'($urandom_range(95, 145));
                        default: ex8 = r[30:23];
                    endcase
                    case ($urandom_range(0, 3))
                        0: fr = 23'h0;
                        1: fr = 23'h7F_FFFF;
                        2: fr = (r[22:0] & 23'h7F_E000) | 23'h1000;
                        default: fr = r[22:0];
                    endcase
                    return {r[31], ex8, fr};
                end
                TY_F16:
                begin
                    case (n)
                        0: return r & 32'hFFFF_0000;
                        1: return (r & 32'hFFFF_0000) | 32'h8000;
                        2: return (r & 32'hFFFF_0000) | 32'h7C00;
                        3: return (r & 32'hFFFF_0000) | 32'hFC00;
                        4: return (r & 32'hFFFF_83FF) | 32'h7C01;
                        5: return (r & 32'hFFFF_0000) | 32'h7BFF;
                        default: ;
                    endcase
                    case (pick)
                        0: ex5 = 5'd0;
                        1: ex5 = 5'd31;
                        2, 3, 4, 5: ex5 = 5'(15 + $urandom_range(0, 16));
                        default: ex5 = r[14:10];
                    endcase
                    fr = (pick == 6) ? 23'h3FF : ((pick == 7) ? 23'h0 : {13'b0, r[9:0]});
                    return {r[31:16], r[15], ex5, fr[9:0]};
                end
                default:
                begin
                    case (n)
                        0: return 32'h0;
                        1: return 32'hFFFF_FFFF;
                        2: return 32'h7FFF_FFFF;
                        3: return 32'h8000_0000;
                        4: return (r & 32'hFFFF_FF00) | 32'h7F;
                        5: return (r & 32'hFFFF_FF00) | 32'h80;
                        default: ;
                    endcase
                    // Values just around the float rounding points of wide integers.
                    if (pick < 3)
                        return r & ~((32'h1 << $urandom_range(0, 24)) - 1);
                    return r;
                end
            endcase
        end
    endfunction

    // One APB write: setup cycle, then access cycle; the register lands at its rising edge.
    task automatic write_type_reg(input logic [0:0] idx, input logic [31:0] value);
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= value;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (idx == REG_SOURCE)
                src_ty = value[2:0];
            else
                dst_ty = value[2:0];
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    // Waits for the block to drain, then lets the pipeline settle before a register write.
    task automatic wait_drained;
        begin
            while (pending_elems.size() != 0 || expected_conversions.size() != 0 || in_valid)
                @(posedge clk);
            repeat (6) @(posedge clk);
        end
    endtask

    // Sender: offers the next pending element at the falling edge, idling at random.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_elems.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data <= pending_elems.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
    always @(negedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predicts every accepted element and checks every accepted result.
    always @(posedge clk)
    begin
        out_item_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            expected_conversions.push_back(convert_element(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_conversions.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h, nothing expected", $time, out_data);
            end
            else
            begin
                want = expected_conversions.pop_front();
                if (out_data.result_bits !== want.result_bits)
                begin
                    errors++;
                    $display("%0t: result_bits expected %h actual %h (src %0d dst %0d)",
                             $time, want.result_bits, out_data.result_bits, src_ty, dst_ty);
                end
                if (out_data.clipped !== want.clipped)
                begin
                    errors++;
                    $display("%0t: clipped expected %b actual %b (result %h)",
                             $time, want.clipped, out_data.clipped, want.result_bits);
                end
                if (out_data.last_result !== want.last_result)
                begin
                    errors++;
                    $display("%0t: last_result expected %b actual %b",
                             $time, want.last_result, out_data.last_result);
                end
            end
        end
        // Watchdog: only counts while work is outstanding and nothing moves.
        if (in_taken || (out_valid && out_ready) ||
            (pending_elems.size() == 0 && expected_conversions.size() == 0 && !in_valid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: every pair of types, each with one of four idle patterns, then unsupported codes.
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        phase_idx = 0;
        for (si = 0; si < 6; si++)
        begin
            for (di = 0; di < 6; di++)
            begin
                wait_drained();
                write_type_reg(REG_SOURCE, 32'(si));
                write_type_reg(REG_TARGET, 32'(di));
                case (phase_idx % 4)
                    0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                    1: begin send_idle_pct = 52; recv_stall_pct = 0; end
                    2: begin send_idle_pct = 0; recv_stall_pct = 52; end
                    default: begin send_idle_pct = 34; recv_stall_pct = 34; end
                endcase
                // One phase starves the output for a long while so the input backs up.
                if (phase_idx == 9)
                    hold_request = ~hold_request;
                for (k = 0; k < ITEMS_PER_SETTING; k++)
                begin
                    elem.element_bits = pick_bits(src_ty, k);
                    elem.last_element = (k == ITEMS_PER_SETTING - 1) || ($urandom_range(0, 7) == 0);
                    pending_elems.push_back(elem);
                end
                phase_idx++;
            end
        end
        // Unused type codes give zero without clipping.
        wait_drained();
        write_type_reg(REG_SOURCE, 32'(6));
        write_type_reg(REG_TARGET, 32'(TY_I8));
        for (k = 0; k < 8; k++)
        begin
            elem.element_bits = $urandom;
            elem.last_element = k[0];
            pending_elems.push_back(elem);
        end
        wait_drained();
        write_type_reg(REG_SOURCE, 32'(TY_F32));
        write_type_reg(REG_TARGET, 32'(7));
        for (k = 0; k < 8; k++)
        begin
            elem.element_bits = $urandom;
            elem.last_element = k[0];
            pending_elems.push_back(elem);
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_conversions.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
